[src/rtpg_pkg.sv]
`timescale 1ns / 1ps

package rtpg_pkg;

	// byte lanes carried by one disk word
	localparam int unsigned BYTE_LANES_DEF = 8;
	localparam int unsigned BYTE_LANES_MAX = 8;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = BYTE_LANES_MAX * BYTE_W;
	localparam int unsigned RESULT_W = 3 * WORD_W;

	// configuration port
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned PCOUNT_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PARITY_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_POLY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_CONST = 2'd2;

	localparam logic [PCOUNT_W-1:0] PCOUNT_PQ = 2'd2;
	localparam logic [PCOUNT_W-1:0] PCOUNT_PQR = 2'd3;

	localparam logic [BYTE_W-1:0] FIELD_POLY_RST = 8'h1d;
	localparam logic [BYTE_W-1:0] HALF_CONST_RST = 8'h8e;

	// next accumulator bytes of one lane
	typedef struct packed {
		logic [BYTE_W-1:0] p;
		logic [BYTE_W-1:0] q;
		logic [BYTE_W-1:0] r;
	} lane_bytes_t;

	function automatic logic [BYTE_W-1:0] gf_double(input logic [BYTE_W-1:0] x,
			input logic [BYTE_W-1:0] poly);
		gf_double = {x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? poly : '0);
	endfunction

	function automatic logic [BYTE_W-1:0] gf_halve(input logic [BYTE_W-1:0] x,
			input logic [BYTE_W-1:0] half);
		gf_halve = {1'b0, x[BYTE_W-1:1]} ^ (x[0] ? half : '0);
	endfunction

endpackage

[src/rtpg_lane.sv]
`timescale 1ns / 1ps

module rtpg_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           first,
	input  logic [rtpg_pkg::BYTE_W-1:0]    data_byte,
	input  logic [rtpg_pkg::BYTE_W-1:0]    field_poly,
	input  logic [rtpg_pkg::BYTE_W-1:0]    half_const,
	output rtpg_pkg::lane_bytes_t          next_bytes
);

	logic [rtpg_pkg::BYTE_W-1:0] p_q;
	logic [rtpg_pkg::BYTE_W-1:0] q_q;
	logic [rtpg_pkg::BYTE_W-1:0] r_q;

	always_comb begin
		if (first) begin
			next_bytes.p = data_byte;
			next_bytes.q = data_byte;
			next_bytes.r = data_byte;
		end else begin
			next_bytes.p = p_q ^ data_byte;
			next_bytes.q = rtpg_pkg::gf_double(q_q, field_poly) ^ data_byte;
			next_bytes.r = rtpg_pkg::gf_halve(r_q, half_const) ^ data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
			q_q <= '0;
			r_q <= '0;
		end else if (en) begin
			p_q <= next_bytes.p;
			q_q <= next_bytes.q;
			r_q <= next_bytes.r;
		end
	end

endmodule

[src/rtpg_merge.sv]
`timescale 1ns / 1ps

module rtpg_merge #(
	parameter int unsigned BYTE_LANES = rtpg_pkg::BYTE_LANES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	input  rtpg_pkg::lane_bytes_t                 lanes [BYTE_LANES],
	input  logic [rtpg_pkg::PCOUNT_W-1:0]         parity_count,
	output logic                                  push_ready,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [rtpg_pkg::RESULT_W-1:0]         m_tdata
);

	localparam int unsigned WORD_W = rtpg_pkg::WORD_W;

	logic [WORD_W-1:0] p_word;
	logic [WORD_W-1:0] q_word;
	logic [WORD_W-1:0] r_word;
	logic [rtpg_pkg::RESULT_W-1:0] result;

	logic                          out_valid_q;
	logic [rtpg_pkg::RESULT_W-1:0] out_data_q;
	logic                          skid_valid_q;
	logic [rtpg_pkg::RESULT_W-1:0] skid_data_q;

	// gather lanes; bytes above the last lane stay zero, and q and r are zeroed when parity_count leaves them out
	always_comb begin
		p_word = '0;
		q_word = '0;
		r_word = '0;
		for (int k = 0; k < BYTE_LANES; k++) begin
			p_word[k*rtpg_pkg::BYTE_W +: rtpg_pkg::BYTE_W] = lanes[k].p;
			q_word[k*rtpg_pkg::BYTE_W +: rtpg_pkg::BYTE_W] = lanes[k].q;
			r_word[k*rtpg_pkg::BYTE_W +: rtpg_pkg::BYTE_W] = lanes[k].r;
		end
		if (parity_count < rtpg_pkg::PCOUNT_PQ)
			q_word = '0;
		if (parity_count < rtpg_pkg::PCOUNT_PQR)
			r_word = '0;
		result = {r_word, q_word, p_word};
	end

	assign push_ready = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (m_tready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			// output stalled: park the transfer in the skid stage
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_valid_q) begin
			if (skid_valid_q)
				out_data_q <= skid_data_q;
			else if (push)
				out_data_q <= result;
		end else if (push) begin
			skid_data_q <= result;
		end
	end

endmodule

[src/raid_triple_parity_gen.sv]
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata = data_word, s_tuser = first_disk,
//                                   s_tlast = last_disk
// m_*       out  m_tvalid/m_tready  m_tdata = p_parity, q_parity, r_parity
// cfg_*     in   cfg_we             cfg_index, cfg_data
//
// One disk word per clock while s_tready is high; the lane accumulators update in the cycle of the transfer.
// A word with s_tlast gives its parities on m_tdata through the output register, or via the skid stage if stalled.
// An output register plus a skid stage keep s_tready high while one result waits;
// s_tready drops only when two results are held.
// Reset clears the accumulators and loads parity_count 3, poly 0x1d, half 0x8e.

module raid_triple_parity_gen #(
	parameter int unsigned BYTE_LANES = rtpg_pkg::BYTE_LANES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rtpg_pkg::WORD_W-1:0]       s_tdata,   // [63:0] data_word
	input  logic                              s_tuser,   // [0] first_disk
	input  logic                              s_tlast,   // last_disk
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rtpg_pkg::RESULT_W-1:0]     m_tdata,   // [63:0] p, [127:64] q, [191:128] r
	input  logic                              cfg_we,
	input  logic [rtpg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rtpg_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [rtpg_pkg::PCOUNT_W-1:0] parity_count_q;
	logic [rtpg_pkg::BYTE_W-1:0]   field_poly_q;
	logic [rtpg_pkg::BYTE_W-1:0]   half_const_q;

	logic                  accept;
	rtpg_pkg::lane_bytes_t lanes [BYTE_LANES];

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_count_q <= rtpg_pkg::PCOUNT_PQR;
			field_poly_q <= rtpg_pkg::FIELD_POLY_RST;
			half_const_q <= rtpg_pkg::HALF_CONST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rtpg_pkg::CFG_PARITY_COUNT: begin
					parity_count_q <= cfg_data[rtpg_pkg::PCOUNT_W-1:0];
				end
				rtpg_pkg::CFG_FIELD_POLY: begin
					field_poly_q <= cfg_data[rtpg_pkg::BYTE_W-1:0];
				end
				rtpg_pkg::CFG_HALF_CONST: begin
					half_const_q <= cfg_data[rtpg_pkg::BYTE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	for (genvar k = 0; k < BYTE_LANES; k++) begin : g_lane
		rtpg_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (accept),
			.first      (s_tuser),
			.data_byte  (s_tdata[k*rtpg_pkg::BYTE_W +: rtpg_pkg::BYTE_W]),
			.field_poly (field_poly_q),
			.half_const (half_const_q),
			.next_bytes (lanes[k])
		);
	end

	rtpg_merge #(
		.BYTE_LANES (BYTE_LANES)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (accept && s_tlast),
		.lanes        (lanes),
		.parity_count (parity_count_q),
		.push_ready   (s_tready),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata)
	);

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

typedef struct packed {
	logic [rtpg_pkg::WORD_W-1:0] r;
	logic [rtpg_pkg::WORD_W-1:0] q;
	logic [rtpg_pkg::WORD_W-1:0] p;
} parity_set_t;

class parity_scoreboard;
	localparam int unsigned W = rtpg_pkg::WORD_W;
	localparam int unsigned B = rtpg_pkg::BYTE_W;

	logic [rtpg_pkg::PCOUNT_W-1:0] parity_count;
	logic [B-1:0] field_poly;
	logic [B-1:0] half_const;
	logic [W-1:0] p_acc;
	logic [W-1:0] q_acc;
	logic [W-1:0] r_acc;
	parity_set_t pending[$];
	int errors;

	function new();
		parity_count = rtpg_pkg::PCOUNT_PQR;
		field_poly = rtpg_pkg::FIELD_POLY_RST;
		half_const = rtpg_pkg::HALF_CONST_RST;
		p_acc = '0;
		q_acc = '0;
		r_acc = '0;
		errors = 0;
	endfunction

	function void write_reg(logic [rtpg_pkg::CFG_IDX_W-1:0] idx,
			logic [rtpg_pkg::CFG_DATA_W-1:0] value);
		case (idx)
			rtpg_pkg::CFG_PARITY_COUNT: parity_count = value[rtpg_pkg::PCOUNT_W-1:0];
			rtpg_pkg::CFG_FIELD_POLY: field_poly = value[B-1:0];
			rtpg_pkg::CFG_HALF_CONST: half_const = value[B-1:0];
			default: ;
		endcase
	endfunction

	// multiply every byte lane by 2 in GF(2^8)
	function logic [W-1:0] doubled(logic [W-1:0] x);
		logic [W-1:0] y;
		logic [B-1:0] b;
		for (int k = 0; k < W / B; k++) begin
			b = x[k*B +: B];
			y[k*B +: B] = {b[B-2:0], 1'b0} ^ (b[B-1] ? field_poly : '0);
		end
		return y;
	endfunction

	// multiply every byte lane by 2^-1 in GF(2^8)
	function logic [W-1:0] halved(logic [W-1:0] x);
		logic [W-1:0] y;
		logic [B-1:0] b;
		for (int k = 0; k < W / B; k++) begin
			b = x[k*B +: B];
			y[k*B +: B] = {1'b0, b[B-1:1]} ^ (b[0] ? half_const : '0);
		end
		return y;
	endfunction

	function void note_word(logic [W-1:0] word, logic first, logic last);
		parity_set_t res;
		if (first) begin
			p_acc = word;
			q_acc = word;
			r_acc = word;
		end else begin
			p_acc = p_acc ^ word;
			q_acc = doubled(q_acc) ^ word;
			r_acc = halved(r_acc) ^ word;
		end
		if (last) begin
			res.p = p_acc;
			res.q = (parity_count >= rtpg_pkg::PCOUNT_PQ) ? q_acc : '0;
			res.r = (parity_count >= rtpg_pkg::PCOUNT_PQR) ? r_acc : '0;
			pending.push_back(res);
		end
	endfunction

	function void check_result(logic [rtpg_pkg::RESULT_W-1:0] data);
		parity_set_t want;
		if (pending.size() == 0) begin
			$error("result with no parity set pending: %h", data);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (data[0 +: W] !== want.p) begin
			$error("p_parity expected %h actual %h", want.p, data[0 +: W]);
			errors++;
		end
		if (data[W +: W] !== want.q) begin
			$error("q_parity expected %h actual %h", want.q, data[W +: W]);
			errors++;
		end
		if (data[2*W +: W] !== want.r) begin
			$error("r_parity expected %h actual %h", want.r, data[2*W +: W]);
			errors++;
		end
	endfunction
endclass

module testbench;

	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned PHASE_ITEMS = 180;
	localparam int unsigned NUM_PHASES = 8;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [rtpg_pkg::WORD_W-1:0]     s_tdata = '0;    // [63:0] data_word
	logic                            s_tuser = 1'b0;  // [0] first_disk
	logic                            s_tlast = 1'b0;  // last_disk
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [rtpg_pkg::RESULT_W-1:0]   m_tdata;         // [63:0] p, [127:64] q, [191:128] r
	logic                            cfg_we = 1'b0;
	logic [rtpg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rtpg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	parity_scoreboard sb;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_req = 0;
	int unsigned sent = 0;
	int unsigned quiet_cycles = 0;

	raid_triple_parity_gen i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// receiver: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int unsigned hold_ack;
		hold_ack = 0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// offer one disk word and hold it until the transfer
	task automatic send_word(input logic [rtpg_pkg::WORD_W-1:0] word, input logic first,
			input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= first;
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_word(word, first, last);
		sent++;
		@(negedge clk);
	endtask

	// stop offering and wait for every pending parity set
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(input logic [rtpg_pkg::CFG_DATA_W-1:0] count,
			input logic [rtpg_pkg::CFG_DATA_W-1:0] poly,
			input logic [rtpg_pkg::CFG_DATA_W-1:0] half);
		cfg_we <= 1'b1;
		cfg_index <= rtpg_pkg::CFG_PARITY_COUNT;
		cfg_data <= count;
		sb.write_reg(rtpg_pkg::CFG_PARITY_COUNT, count);
		@(negedge clk);
		cfg_index <= rtpg_pkg::CFG_FIELD_POLY;
		cfg_data <= poly;
		sb.write_reg(rtpg_pkg::CFG_FIELD_POLY, poly);
		@(negedge clk);
		cfg_index <= rtpg_pkg::CFG_HALF_CONST;
		cfg_data <= half;
		sb.write_reg(rtpg_pkg::CFG_HALF_CONST, half);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [rtpg_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(9))
			0: return '1;
			1: return '0;
			2: return {8{8'h80}};
			3: return {8{8'h01}};
			4: return {8{8'h81}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// mostly whole columns; some with a dropped mark, some stray words
	task automatic random_column();
		int unsigned disks;
		logic first;
		logic last;
		if ($urandom_range(99) < 12) begin
			send_word(pick_word(), 1'($urandom_range(1)), 1'($urandom_range(1)));
		end else begin
			disks = ($urandom_range(19) == 0) ? $urandom_range(32, 9) : $urandom_range(8, 1);
			for (int d = 0; d < disks; d++) begin
				first = (d == 0) && ($urandom_range(19) != 0);
				last = (d == disks - 1) && ($urandom_range(19) != 0);
				send_word(pick_word(), first, last);
			end
		end
	endtask

	initial begin
		logic [rtpg_pkg::CFG_DATA_W-1:0] count;
		logic [rtpg_pkg::CFG_DATA_W-1:0] poly;
		logic [rtpg_pkg::CFG_DATA_W-1:0] half;
		sb = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// no start mark right after reset: continue from cleared accumulators
		send_word(64'h0123_4567_89ab_cdef, 1'b0, 1'b1);
		send_word('1, 1'b1, 1'b1);
		send_word('0, 1'b1, 1'b1);
		send_word({8{8'h80}}, 1'b1, 1'b0);
		send_word({8{8'h01}}, 1'b0, 1'b0);
		send_word('1, 1'b0, 1'b1);
		// emission leaves the accumulators as they are
		send_word({8{8'h80}}, 1'b0, 1'b1);
		send_word('1, 1'b1, 1'b0);
		send_word('0, 1'b0, 1'b0);
		send_word({8{8'h80}}, 1'b0, 1'b0);
		send_word({8{8'h01}}, 1'b0, 1'b1);
		// a second start mark mid column restarts it
		send_word({$urandom, $urandom}, 1'b1, 1'b0);
		send_word({$urandom, $urandom}, 1'b1, 1'b0);
		send_word({$urandom, $urandom}, 1'b0, 1'b1);
		send_word({8{8'h55}}, 1'b1, 1'b0);
		send_word({8{8'haa}}, 1'b0, 1'b1);
		send_word({$urandom, $urandom}, 1'b0, 1'b0);
		send_word({$urandom, $urandom}, 1'b0, 1'b1);
		drain();

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				1: begin count = 8'd0; poly = 8'h00; half = 8'h00; end
				2: begin count = 8'd1; poly = 8'hff; half = 8'hff; end
				3: begin count = 8'd2; poly = 8'($urandom); half = 8'($urandom); end
				4: begin count = 8'd3; poly = 8'hff; half = 8'h00; end
				5: begin count = 8'd3; poly = 8'h00; half = 8'hff; end
				6: begin count = 8'd2; poly = 8'h1d; half = 8'h8e; end
				default: begin count = 8'd3; poly = 8'($urandom); half = 8'($urandom); end
			endcase
			if (phase != 0)
				set_config(count, poly, half);
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 60; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 60; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			if (phase == 0) begin
				// long receiver hold-off while single-disk columns keep coming
				hold_req++;
				for (int i = 0; i < 16; i++)
					send_word({$urandom, $urandom}, 1'b1, 1'b1);
				drain();
			end
			while (sent < (phase + 1) * PHASE_ITEMS + 20) begin
				random_column();
				if ($urandom_range(99) == 0)
					drain();
			end
			drain();
		end

		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
